FILE: rtl/core/ssf_pkg.sv
// Shared types, mode and command codes, and the move table for the safety supervisor.
// No dependencies.
package ssf_pkg;

  localparam logic [2:0] MODE_BOOT     = 3'd0;
  localparam logic [2:0] MODE_STANDBY  = 3'd1;
  localparam logic [2:0] MODE_READY    = 3'd2;
  localparam logic [2:0] MODE_ACTIVE   = 3'd3;
  localparam logic [2:0] MODE_DEGRADED = 3'd4;
  localparam logic [2:0] MODE_FAILSAFE = 3'd5;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_LINK    = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] REG_HEARTBEAT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_REJECT_THRESHOLD  = 2'd1;

  localparam logic [31:0] HEARTBEAT_TIMEOUT_RESET = 32'd100000;
  localparam logic [15:0] REJECT_THRESHOLD_RESET  = 16'd3;

  typedef struct packed {
    logic [31:0] heartbeat_timeout;
    logic [15:0] reject_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  target_state;
    logic        ai_authority;
    logic        range_ok;
    logic [63:0] now_time;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  mode;
    logic        kick_ok;
    logic [31:0] entries;
    logic [31:0] recoveries;
    logic [31:0] rejects;
    logic [31:0] run_rejects;
  } result_t;

  // bit t set: move to mode t allowed
  function automatic logic [5:0] move_mask(input logic [2:0] from);
    logic [5:0] m;
    m = 6'b0;
    unique case (from)
      MODE_BOOT:     m = 6'b100010;
      MODE_STANDBY:  m = 6'b100100;
      MODE_READY:    m = 6'b111000;
      MODE_ACTIVE:   m = 6'b110100;
      MODE_DEGRADED: m = 6'b101100;
      MODE_FAILSAFE: m = 6'b000010;
      default:       m = 6'b000000;
    endcase
    return m;
  endfunction

  function automatic logic move_ok(input logic [2:0] from, input logic [2:0] to);
    logic [5:0] m;
    m = move_mask(from);
    if (from == to) begin
      return 1'b1;
    end
    if (to > MODE_FAILSAFE) begin
      return 1'b0;
    end
    return m[to];
  endfunction

endpackage

FILE: rtl/core/ssf_cfg_regs.sv
// Configuration registers of the safety supervisor: heartbeat timeout and reject threshold.
// Depends on ssf_pkg.
module ssf_cfg_regs
  import ssf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_timeout <= HEARTBEAT_TIMEOUT_RESET;
      cfg.reject_threshold  <= REJECT_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HEARTBEAT_TIMEOUT) begin
        cfg.heartbeat_timeout <= cfg_data;
      end else if (cfg_index == REG_REJECT_THRESHOLD) begin
        cfg.reject_threshold <= cfg_data[15:0];
      end
    end
  end

endmodule

FILE: rtl/core/ssf_engine.sv
// Supervisor state and the per-item update: move table, counters, heartbeat check.
// Depends on ssf_pkg.
module ssf_engine
  import ssf_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [2:0]             mode, mode_next;
  logic                   kick, kick_next;
  logic [63:0]            last_rx, last_rx_next;
  logic [COUNT_WIDTH-1:0] entries, entries_next;
  logic [COUNT_WIDTH-1:0] recov, recov_next;
  logic [COUNT_WIDTH-1:0] rtot, rtot_next;
  logic [COUNT_WIDTH-1:0] rrun, rrun_next;
  logic [COUNT_WIDTH-1:0] rrun_inc;
  logic                   try_en;
  logic [2:0]             try_to;
  logic                   move_allowed;
  logic                   acc;
  logic                   timed_out;
  logic [63:0]            elapsed;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign rrun_inc = sat_inc(rrun);
  assign elapsed  = item.now_time - last_rx;
  assign timed_out = (last_rx == 64'd0) || (item.now_time < last_rx)
                     || (elapsed > {32'd0, cfg.heartbeat_timeout});
  assign move_allowed = move_ok(mode, try_to);

  always_comb begin
    try_en       = 1'b0;
    try_to       = item.target_state;
    recov_next   = recov;
    rtot_next    = rtot;
    rrun_next    = rrun;
    last_rx_next = last_rx;
    unique case (item.command)
      CMD_REQUEST: begin
        try_en = 1'b1;
        try_to = item.target_state;
      end
      CMD_CLEAR: begin
        if (mode == MODE_FAILSAFE) begin
          try_en     = 1'b1;
          try_to     = MODE_STANDBY;
          recov_next = sat_inc(recov);
          rrun_next  = '0;
        end
      end
      CMD_LINK: begin
        last_rx_next = item.now_time;
        try_en = 1'b1;
        if (item.ai_authority && item.range_ok) begin
          rrun_next = '0;
          try_to    = MODE_ACTIVE;
        end else if (!item.range_ok) begin
          rtot_next = sat_inc(rtot);
          rrun_next = rrun_inc;
          try_to    = (32'(rrun_inc) >= 32'(cfg.reject_threshold)) ?
                      MODE_FAILSAFE : MODE_DEGRADED;
        end else begin
          rrun_next = '0;
          try_to    = MODE_DEGRADED;
        end
      end
      CMD_TICK: begin
        try_to = MODE_FAILSAFE;
        if ((mode == MODE_READY || mode == MODE_ACTIVE || mode == MODE_DEGRADED)
            && timed_out) begin
          try_en = 1'b1;
        end
      end
      default: begin
        try_en = 1'b0;
      end
    endcase

    acc          = try_en && move_allowed;
    mode_next    = mode;
    kick_next    = kick;
    entries_next = entries;
    if (acc) begin
      mode_next = try_to;
      kick_next = (try_to == MODE_READY) || (try_to == MODE_ACTIVE)
                  || (try_to == MODE_DEGRADED);
      if (try_to == MODE_FAILSAFE && mode != MODE_FAILSAFE) begin
        entries_next = sat_inc(entries);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_BOOT;
      kick    <= 1'b0;
      last_rx <= 64'd0;
      entries <= '0;
      recov   <= '0;
      rtot    <= '0;
      rrun    <= '0;
    end else if (fire) begin
      mode    <= mode_next;
      kick    <= kick_next;
      last_rx <= last_rx_next;
      entries <= entries_next;
      recov   <= recov_next;
      rtot    <= rtot_next;
      rrun    <= rrun_next;
    end
  end

  assign res.accepted    = acc;
  assign res.mode        = mode_next;
  assign res.kick_ok     = kick_next;
  assign res.entries     = 32'(entries_next);
  assign res.recoveries  = 32'(recov_next);
  assign res.rejects     = 32'(rtot_next);
  assign res.run_rejects = 32'(rrun_next);

endmodule

FILE: rtl/core/safety_supervisor_fsm_top.sv
// Safety supervisor with six modes, event input channel, result output channel and config port.
// Depends on ssf_pkg, ssf_cfg_regs and ssf_engine.
//
// Usage:
//   Input channel (in_valid / in_stall): one event item per accepted cycle.
//   Output channel (out_valid / out_stall): one result item per event, in order.
//   Config port (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 heartbeat
//   timeout, index 1 reject threshold; other indexes are ignored. cfg_ready is
//   always high. Write only while no item is in flight.
// Pipeline: an accepted item waits in the input register; when it advances, the engine
//   state and the result registers load together and out_valid rises with them.
// Throughput: one item per cycle while results are not stalled; the mode and counter
//   update for one item is a single pass through the move table, saturating increments
//   and the 64-bit heartbeat subtract and compare between the input and result registers.
// Reset: synchronous; mode boot, kick off, counters and last receive time zero,
//   config back to timeout 100000 and threshold 3, both pipeline stages empty.
// Stall: while out_stall holds a result, one more item can sit in the input
//   register; after that in_stall rises until the result is taken.
module safety_supervisor_fsm_top
  import ssf_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  target_state,
  input  logic        ai_authority,
  input  logic        range_ok,
  input  logic [63:0] now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [2:0]  mode_out,
  output logic        kick_ok,
  output logic [31:0] entries_out,
  output logic [31:0] recoveries_out,
  output logic [31:0] rejects_out,
  output logic [31:0] run_rejects_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    fire;
  logic    take;
  result_t res;

  ssf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssf_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.command      <= command;
      s1_item.target_state <= target_state;
      s1_item.ai_authority <= ai_authority;
      s1_item.range_ok     <= range_ok;
      s1_item.now_time     <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted        <= res.accepted;
      mode_out        <= res.mode;
      kick_ok         <= res.kick_ok;
      entries_out     <= res.entries;
      recoveries_out  <= res.recoveries;
      rejects_out     <= res.rejects;
      run_rejects_out <= res.run_rejects;
    end
  end

endmodule

FILE: test/safety_supervisor_fsm_tb.sv
// Self-checking testbench for safety_supervisor_fsm_top: a directed walk through the mode
// table, clear, link and heartbeat cases, then random event streams under several settings.
// Depends on ssf_pkg and the safety supervisor RTL.
`timescale 1ns / 1ps

module testbench
  import ssf_pkg::*;
();

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 170;
  localparam int REPORT_LIMIT = 10;
  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  class supervisor_scoreboard;
    logic [31:0] hb_timeout;
    logic [15:0] rej_threshold;
    logic [2:0]  mode;
    logic        kick;
    logic [63:0] last_rx;
    logic [31:0] entries;
    logic [31:0] recoveries;
    logic [31:0] rej_total;
    logic [31:0] rej_run;
    result_t     pending_results[$];
    int          errors;
    int          checked;

    function new();
      hb_timeout    = HEARTBEAT_TIMEOUT_RESET;
      rej_threshold = REJECT_THRESHOLD_RESET;
      mode          = MODE_BOOT;
      kick          = 1'b0;
      last_rx       = '0;
      entries       = '0;
      recoveries    = '0;
      rej_total     = '0;
      rej_run       = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function bit may_move(logic [2:0] from, logic [2:0] to);
      if (from == to) begin
        return 1'b1;
      end
      case (from)
        MODE_BOOT:     return to inside {MODE_STANDBY, MODE_FAILSAFE};
        MODE_STANDBY:  return to inside {MODE_READY, MODE_FAILSAFE};
        MODE_READY:    return to inside {MODE_ACTIVE, MODE_DEGRADED, MODE_FAILSAFE};
        MODE_ACTIVE:   return to inside {MODE_READY, MODE_DEGRADED, MODE_FAILSAFE};
        MODE_DEGRADED: return to inside {MODE_READY, MODE_ACTIVE, MODE_FAILSAFE};
        MODE_FAILSAFE: return to == MODE_STANDBY;
        default:       return 1'b0;
      endcase
    endfunction

    function bit try_move(logic [2:0] to);
      if (!may_move(mode, to)) begin
        return 1'b0;
      end
      if (to == MODE_FAILSAFE && mode != MODE_FAILSAFE) begin
        entries = bump(entries);
      end
      mode = to;
      kick = to inside {MODE_READY, MODE_ACTIVE, MODE_DEGRADED};
      return 1'b1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_HEARTBEAT_TIMEOUT: hb_timeout = data;
        REG_REJECT_THRESHOLD:  rej_threshold = data[15:0];
        default: ;
      endcase
    endfunction

    // predicts the result of one accepted event item
    function void note_event(item_t it);
      bit      ok;
      result_t r;
      ok = 1'b0;
      case (it.command)
        CMD_REQUEST: ok = try_move(it.target_state);
        CMD_CLEAR: begin
          if (mode == MODE_FAILSAFE && try_move(MODE_STANDBY)) begin
            recoveries = bump(recoveries);
            rej_run = '0;
            ok = 1'b1;
          end
        end
        CMD_LINK: begin
          last_rx = it.now_time;
          if (it.ai_authority && it.range_ok) begin
            rej_run = '0;
            ok = try_move(MODE_ACTIVE);
          end else if (!it.range_ok) begin
            rej_total = bump(rej_total);
            rej_run = bump(rej_run);
            ok = try_move(rej_run >= {16'd0, rej_threshold} ? MODE_FAILSAFE : MODE_DEGRADED);
          end else begin
            rej_run = '0;
            ok = try_move(MODE_DEGRADED);
          end
        end
        CMD_TICK: begin
          if (mode inside {MODE_READY, MODE_ACTIVE, MODE_DEGRADED} &&
              (last_rx == '0 || it.now_time < last_rx ||
               it.now_time - last_rx > {32'd0, hb_timeout})) begin
            ok = try_move(MODE_FAILSAFE);
          end
        end
      endcase
      r.accepted    = ok;
      r.mode        = mode;
      r.kick_ok     = kick;
      r.entries     = entries;
      r.recoveries  = recoveries;
      r.rejects     = rej_total;
      r.run_rejects = rej_run;
      pending_results.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        flag($sformatf("result %0d %s expected %0h actual %0h", checked, name, want, got));
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        flag($sformatf("result %0d arrived with no event pending", checked));
        return;
      end
      want = pending_results.pop_front();
      cmp("accepted", 32'(want.accepted), 32'(got.accepted));
      cmp("mode_out", 32'(want.mode), 32'(got.mode));
      cmp("kick_ok", 32'(want.kick_ok), 32'(got.kick_ok));
      cmp("entries_out", want.entries, got.entries);
      cmp("recoveries_out", want.recoveries, got.recoveries);
      cmp("rejects_out", want.rejects, got.rejects);
      cmp("run_rejects_out", want.run_rejects, got.run_rejects);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_REQUEST;
  logic [2:0]  target_state = MODE_BOOT;
  logic        ai_authority = 1'b0;
  logic        range_ok = 1'b0;
  logic [63:0] now_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [2:0]  mode_out;
  logic        kick_ok;
  logic [31:0] entries_out;
  logic [31:0] recoveries_out;
  logic [31:0] rejects_out;
  logic [31:0] run_rejects_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_HEARTBEAT_TIMEOUT;
  logic [31:0] cfg_data = '0;

  supervisor_scoreboard sb;

  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          cfg_writes = 0;
  logic [63:0] now_us = 64'd1000;

  int          gap_plan[4]   = '{0, 49, 0, 22};
  int          stall_plan[4] = '{0, 0, 49, 22};
  logic [31:0] tmo_plan[4]   = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd150000};
  logic [15:0] thr_plan[4]   = '{16'd0, 16'hFFFF, 16'd1, 16'd2};

  safety_supervisor_fsm_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    item_t   seen;
    result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.command      = command;
        seen.target_state = target_state;
        seen.ai_authority = ai_authority;
        seen.range_ok     = range_ok;
        seen.now_time     = now_time;
        sb.note_event(seen);
      end
      if (out_valid && !out_stall) begin
        got.accepted    = accepted;
        got.mode        = mode_out;
        got.kick_ok     = kick_ok;
        got.entries     = entries_out;
        got.recoveries  = recoveries_out;
        got.rejects     = rejects_out;
        got.run_rejects = run_rejects_out;
        sb.check_result(got);
      end
    end
  end

  function automatic item_t make_event(logic [1:0] cmd, logic [2:0] tgt, logic auth,
                                       logic rok, logic [63:0] t);
    item_t it;
    it.command      = cmd;
    it.target_state = tgt;
    it.ai_authority = auth;
    it.range_ok     = rok;
    it.now_time     = t;
    return it;
  endfunction

  // mostly a forward-running clock, with zero, backward and wild values mixed in
  function automatic logic [63:0] next_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      return 64'd0;
    end
    if (pick < 8) begin
      return {$urandom, $urandom};
    end
    if (pick < 14) begin
      return now_us - 64'($urandom_range(1000));
    end
    if (pick < 24) begin
      return now_us;
    end
    if (pick < 30) begin
      now_us = now_us + {28'd0, 4'($urandom_range(15)), 32'($urandom)};
    end else if (pick < 55) begin
      now_us = now_us + 64'($urandom_range(300000));
    end else begin
      now_us = now_us + 64'($urandom_range(2000));
    end
    return now_us;
  endfunction

  function automatic item_t random_event();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.command = CMD_LINK;
    end else if (pick < 58) begin
      it.command = CMD_REQUEST;
    end else if (pick < 83) begin
      it.command = CMD_TICK;
    end else begin
      it.command = CMD_CLEAR;
    end
    if ($urandom_range(99) < 85) begin
      it.target_state = 3'($urandom_range(5));
    end else begin
      it.target_state = 3'($urandom_range(7, 6));
    end
    it.ai_authority = 1'($urandom_range(1));
    it.range_ok     = ($urandom_range(99) < 70);
    it.now_time     = next_time();
    return it;
  endfunction

  task automatic send_event(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= it.command;
    target_state <= it.target_state;
    ai_authority <= it.ai_authority;
    range_ok     <= it.range_ok;
    now_time     <= it.now_time;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering items and let every pending result come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: table edges, clear, link outcomes and heartbeat cases at reset settings
    send_event(make_event(CMD_REQUEST, 3'd7, 1'b1, 1'b1, 64'd0));
    send_event(make_event(CMD_REQUEST, 3'd6, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_CLEAR, MODE_BOOT, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd5));
    send_event(make_event(CMD_REQUEST, MODE_BOOT, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_ACTIVE, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_STANDBY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_READY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd1000));
    send_event(make_event(CMD_REQUEST, MODE_READY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_CLEAR, MODE_BOOT, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_READY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b1, 1'b1, 64'd1000));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd101000));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd101001));
    send_event(make_event(CMD_CLEAR, MODE_BOOT, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_READY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b0, 1'b0, TIME_MAX));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd5));
    send_event(make_event(CMD_CLEAR, MODE_BOOT, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_REQUEST, MODE_READY, 1'b0, 1'b0, 64'd0));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b1, 1'b0, 64'd0));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b0, 1'b1, 64'd2000));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b0, 1'b0, 64'd2100));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b0, 1'b0, 64'd2200));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b0, 1'b0, 64'd2300));
    send_event(make_event(CMD_TICK, MODE_BOOT, 1'b0, 1'b0, 64'd9000000));
    send_event(make_event(CMD_LINK, MODE_BOOT, 1'b1, 1'b1, 64'd9000000));

    for (int p = 0; p < 4; p++) begin
      drain();
      cfg_write(REG_HEARTBEAT_TIMEOUT, tmo_plan[p]);
      cfg_write(REG_REJECT_THRESHOLD, {16'($urandom), thr_plan[p]});
      if (p == 0) begin
        cfg_write(REG_SPARE, $urandom);
      end
      send_gap_pct = gap_plan[p];
      stall_pct    = stall_plan[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p != 1) begin
          hold_requests++;
        end
        send_event(random_event());
      end
    end
    drain();
    repeat (10) @(posedge clk);

    $display("run covered %0d event items, %0d results checked, %0d register writes,",
             items_sent, sb.checked, cfg_writes);
    $display("four idle/stall mixes and %0d long output hold-offs; %0d mismatches",
             hold_requests, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: safety_supervisor_fsm_top.f
rtl/core/ssf_pkg.sv
rtl/core/ssf_cfg_regs.sv
rtl/core/ssf_engine.sv
rtl/core/safety_supervisor_fsm_top.sv
test/safety_supervisor_fsm_tb.sv
